[rtl/core/lsc_pkg.sv]
// lsc_pkg: shared widths, constants and types of the lattice spin chirality block
// no dependencies; imported by lsc_scale and lattice_spin_chirality
`default_nettype none

package lsc_pkg;

  // default sizing of the lattice stores
  localparam int LSC_MAX_SITES = 1024;
  localparam int LSC_SPIN_BITS = 16;

  // fixed field widths
  localparam int SITE_W   = 10;
  localparam int NBR_W    = 11;
  localparam int SPIN_W   = 16;
  localparam int CMP_W    = 17;
  localparam int CHARGE_W = 32;
  localparam int TOTAL_W  = 48;

  // datapath widths: cross product component, dot product term, pair sum
  localparam int PROD_W  = 32;
  localparam int CROSS_W = 33;
  localparam int DOT_W   = 49;
  localparam int ACC_W   = 52;

  // scaling by round(2^32 / (8 pi)), magnitude split at bit 25
  localparam int RECIP_W     = 28;
  localparam int SPLIT       = 25;
  localparam int LO_W        = 54;
  localparam int HI_W        = 55;
  localparam int ROUND_POS   = 46;
  localparam int FINAL_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_8PI = 28'd170891319;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  // input function codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef logic signed [SPIN_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } scale_ctl_t;

endpackage

`default_nettype wire

[rtl/core/lsc_scale.sv]
// lsc_scale: two-stage scaling of the summed triple products by 1/(8 pi)
// depends on lsc_pkg; rounds half away from zero to a signed Q2.30 charge
`default_nettype none

module lsc_scale import lsc_pkg::*; (
  input  wire logic                       clk,
  input  wire scale_ctl_t                 ctl,
  input  wire logic signed [ACC_W-1:0]    acc,
  output logic signed [CHARGE_W-1:0]      charge
);

  logic                     neg_nxt;
  logic                     neg_r;
  logic [ACC_W-1:0]         mag;
  logic [SPLIT-1:0]         mag_lo;
  logic [ACC_W-SPLIT-1:0]   mag_hi;
  logic [LO_W-1:0]          lo_nxt;
  logic [LO_W-1:0]          lo_r;
  logic [HI_W-1:0]          hi_nxt;
  logic [HI_W-1:0]          hi_r;
  logic [HI_W:0]            qsum;
  logic [CHARGE_W-1:0]      q;
  logic signed [CHARGE_W-1:0] charge_nxt;
  logic signed [CHARGE_W-1:0] charge_r;

  always_comb begin
    neg_nxt = acc[ACC_W-1];
    mag     = neg_nxt ? (ACC_W'(0) - $unsigned(acc)) : $unsigned(acc);
    mag_lo  = mag[SPLIT-1:0];
    mag_hi  = mag[ACC_W-1:SPLIT];
    // low partial product carries the rounding half
    lo_nxt  = LO_W'(mag_lo) * LO_W'(RECIP_8PI) + (LO_W'(1) << ROUND_POS);
    hi_nxt  = HI_W'(mag_hi) * HI_W'(RECIP_8PI);
  end

  always_comb begin
    qsum       = (HI_W+1)'(hi_r) + (HI_W+1)'(lo_r >> SPLIT);
    q          = qsum[FINAL_SHIFT +: CHARGE_W];
    charge_nxt = neg_r ? $signed(CHARGE_W'(0) - q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      neg_r <= neg_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
    if (ctl.rnd_en) begin
      charge_r <= charge_nxt;
    end
  end

  assign charge = charge_r;

endmodule

`default_nettype wire

[rtl/core/lattice_spin_chirality.sv]
// lattice_spin_chirality: top level of the discrete skyrmion number engine
// depends on lsc_pkg and lsc_scale; holds the spin and neighbour memories
//
// usage
//   input channel (in_valid / in_stall): a load item (in_func = 0) writes one
//   site's spin and its four neighbour indices; a compute item (in_func = 1)
//   reports the scalar chirality of in_site and adds it to a running total
//   (in_restart = 1 clears the total and the saturation flag first)
//   result channel (out_valid / out_stall): one item per compute of a site
//   below MAX_SITES, none for loads; out-of-range items are dropped
// timing
//   loads may follow each other in every cycle while no compute is reading
//   its neighbours and the pipeline is not held; a compute issues five reads
//   on the single spin memory port (the site, then -x, -y, +x, +y), so the
//   next item is taken only after its four neighbour reads
// reset
//   rst_n clears the pipeline, the output valid, total and flag; the
//   memories are not cleared, a site must be loaded before use
// stall
//   a result waits in the output register while the next items are taken;
//   only when a second result is due does the whole pipeline hold
`default_nettype none

module lattice_spin_chirality import lsc_pkg::*; #(
  parameter int MAX_SITES = LSC_MAX_SITES,
  parameter int SPIN_BITS = LSC_SPIN_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_func,
  input  wire logic [SITE_W-1:0]          in_site,
  input  wire logic signed [SPIN_W-1:0]   in_spin_x,
  input  wire logic signed [SPIN_W-1:0]   in_spin_y,
  input  wire logic signed [SPIN_W-1:0]   in_spin_z,
  input  wire logic signed [NBR_W-1:0]    in_nbr_minus_x,
  input  wire logic signed [NBR_W-1:0]    in_nbr_plus_x,
  input  wire logic signed [NBR_W-1:0]    in_nbr_minus_y,
  input  wire logic signed [NBR_W-1:0]    in_nbr_plus_y,
  input  wire logic                       in_restart,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [SITE_W-1:0]               out_site,
  output logic signed [CHARGE_W-1:0]      out_site_charge,
  output logic signed [TOTAL_W-1:0]       out_running_total,
  output logic                            out_saturated
);

  // addressable depth is bounded by the 10-bit site field
  localparam int DEPTH   = (MAX_SITES < (1 << SITE_W)) ? MAX_SITES : (1 << SITE_W);
  localparam int AW      = $clog2(DEPTH);
  localparam int EFF     = (SPIN_BITS < SPIN_W) ? SPIN_BITS : SPIN_W;
  localparam int DROP    = SPIN_W - EFF;
  localparam int SPIN_MW = 3 * EFF;
  localparam int NE      = AW + 1;
  localparam int NBR_MW  = 4 * NE;
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_SITES);

  // neighbour slots inside a memory word
  localparam int SLOT_MX = 0;
  localparam int SLOT_PX = 1;
  localparam int SLOT_MY = 2;
  localparam int SLOT_PY = 3;

  // memories
  logic [SPIN_MW-1:0]  spin_mem [DEPTH];
  logic [NBR_MW-1:0]   nbr_mem  [DEPTH];
  logic [SPIN_MW-1:0]  spin_q;
  logic [NBR_MW-1:0]   nbr_q;

  // control
  logic                advance;
  logic                accept;
  logic                site_ok;
  logic                start;
  logic                load_we;
  logic [9:1]          v_r;
  logic                front_busy;
  logic                spin_en;
  logic [AW-1:0]       spin_addr;
  logic [SPIN_MW-1:0]  spin_wdata;
  logic [NBR_MW-1:0]   nbr_wdata;
  logic [1:0]          rd_slot;
  logic [1:0]          pres_slot;
  logic                pres;

  // item tags: front half (reads) and back half (arithmetic)
  logic [SITE_W-1:0]   tag_f_site_r;
  logic                tag_f_rst_r;
  logic [SITE_W-1:0]   tag_b_site_r;
  logic                tag_b_rst_r;

  // datapath
  vec_t                rd_vec;
  vec_t                op_vec;
  vec_t                s_r;
  logic signed [PROD_W-1:0]  m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  logic signed [CROSS_W-1:0] wx_nxt, wy_nxt, wz_nxt;
  logic signed [CROSS_W-1:0] wx_r, wy_r, wz_r;
  logic signed [DOT_W-1:0]   px_nxt, py_nxt, pz_nxt;
  logic signed [DOT_W-1:0]   px_r, py_r, pz_r;
  logic signed [ACC_W-1:0]   psum;
  logic signed [ACC_W-1:0]   acc_r;
  scale_ctl_t                scale_ctl;
  logic signed [CHARGE_W-1:0] charge;

  // running total
  logic signed [TOTAL_W-1:0] base;
  logic signed [TOTAL_W:0]   nt;
  logic                      clip_hi;
  logic                      clip_lo;
  logic [TOTAL_W-1:0]        total_nxt;
  logic                      sat_nxt;
  logic [TOTAL_W-1:0]        total_r;
  logic                      sat_r;

  // output register
  logic                      out_valid_r;
  logic [SITE_W-1:0]         out_site_r;
  logic signed [CHARGE_W-1:0] out_charge_r;
  logic [TOTAL_W-1:0]        out_total_r;
  logic                      out_sat_r;

  // present if non-negative and below MAX_SITES
  function automatic logic [NE-1:0] nbr_entry(input logic [NBR_W-1:0] idx);
    logic present;
    present = !idx[NBR_W-1] && (CMP_W'(idx[NBR_W-2:0]) < MAX_W);
    return {present, idx[AW-1:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // handshake and sequencing
  // ---------------------------------------------------------------------------

  // hold everything only when a finished result meets a full, stalled output
  assign advance    = !(v_r[9] && out_valid_r && out_stall);
  // v_r[1..4] own the spin port for the neighbour reads
  assign front_busy = v_r[1] | v_r[2] | v_r[3] | v_r[4];
  assign in_stall   = !advance || front_busy;
  assign accept     = in_valid && !in_stall;
  assign site_ok    = CMP_W'(in_site) < MAX_W;
  assign start      = accept && site_ok && (in_func == FUNC_COMPUTE);
  assign load_we    = accept && site_ok && (in_func == FUNC_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[8:1], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tag_f_site_r <= in_site;
      tag_f_rst_r  <= in_restart;
    end
    if (advance && v_r[4]) begin
      tag_b_site_r <= tag_f_site_r;
      tag_b_rst_r  <= tag_f_rst_r;
    end
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------

  // neighbour slot read out in each front cycle: -x, -y, +x, +y
  always_comb begin
    rd_slot = 2'(SLOT_PY);
    if (v_r[1]) begin
      rd_slot = 2'(SLOT_MX);
    end else if (v_r[2]) begin
      rd_slot = 2'(SLOT_MY);
    end else if (v_r[3]) begin
      rd_slot = 2'(SLOT_PX);
    end
  end

  always_comb begin
    spin_en    = advance && (accept || front_busy);
    spin_addr  = front_busy ? nbr_q[rd_slot*NE +: AW] : in_site[AW-1:0];
    spin_wdata = {in_spin_x[SPIN_W-1 -: EFF], in_spin_y[SPIN_W-1 -: EFF],
                  in_spin_z[SPIN_W-1 -: EFF]};
    nbr_wdata  = {nbr_entry(in_nbr_plus_y), nbr_entry(in_nbr_minus_y),
                  nbr_entry(in_nbr_plus_x), nbr_entry(in_nbr_minus_x)};
  end

  // single port: a load writes, a compute reads
  always_ff @(posedge clk) begin
    if (spin_en) begin
      if (load_we) begin
        spin_mem[spin_addr] <= spin_wdata;
      end else begin
        spin_q <= spin_mem[spin_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      nbr_mem[in_site[AW-1:0]] <= nbr_wdata;
    end else if (start) begin
      nbr_q <= nbr_mem[in_site[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // triple products, S.(A x B) = B.(S x A): unless the pipeline holds, one spin per cycle
  // ---------------------------------------------------------------------------

  // presence of the spin now leaving the memory
  always_comb begin
    pres_slot = 2'(SLOT_PY);
    if (v_r[2]) begin
      pres_slot = 2'(SLOT_MX);
    end else if (v_r[3]) begin
      pres_slot = 2'(SLOT_MY);
    end else if (v_r[4]) begin
      pres_slot = 2'(SLOT_PX);
    end
    pres = nbr_q[pres_slot*NE + AW];
  end

  // stored components keep the top bits, the rest reads as zero
  always_comb begin
    rd_vec.x = comp_t'(SPIN_W'(spin_q[2*EFF +: EFF]) << DROP);
    rd_vec.y = comp_t'(SPIN_W'(spin_q[EFF +: EFF]) << DROP);
    rd_vec.z = comp_t'(SPIN_W'(spin_q[0 +: EFF]) << DROP);
    op_vec   = pres ? rd_vec : '0;
  end

  always_comb begin
    m_yz   = s_r.y * op_vec.z;
    m_zy   = s_r.z * op_vec.y;
    m_zx   = s_r.z * op_vec.x;
    m_xz   = s_r.x * op_vec.z;
    m_xy   = s_r.x * op_vec.y;
    m_yx   = s_r.y * op_vec.x;
    wx_nxt = CROSS_W'(m_yz) - CROSS_W'(m_zy);
    wy_nxt = CROSS_W'(m_zx) - CROSS_W'(m_xz);
    wz_nxt = CROSS_W'(m_xy) - CROSS_W'(m_yx);
    px_nxt = op_vec.x * wx_r;
    py_nxt = op_vec.y * wy_r;
    pz_nxt = op_vec.z * wz_r;
    psum   = ACC_W'(px_r) + ACC_W'(py_r) + ACC_W'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // the site's own spin arrives first
      if (v_r[1]) begin
        s_r <= rd_vec;
      end
      // cross product with -x, later with +x
      if (v_r[2] || v_r[4]) begin
        wx_r <= wx_nxt;
        wy_r <= wy_nxt;
        wz_r <= wz_nxt;
      end
      // dot product with -y, later with +y
      if (v_r[3] || v_r[5]) begin
        px_r <= px_nxt;
        py_r <= py_nxt;
        pz_r <= pz_nxt;
      end
      // first triple, then the sum of both
      if (v_r[4]) begin
        acc_r <= psum;
      end else if (v_r[6]) begin
        acc_r <= acc_r + psum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scaling to Q2.30
  // ---------------------------------------------------------------------------

  // mul_en, rnd_en
  assign scale_ctl = {advance && v_r[7], advance && v_r[8]};

  lsc_scale u_scale (
    .clk    (clk),
    .ctl    (scale_ctl),
    .acc    (acc_r),
    .charge (charge)
  );

  // ---------------------------------------------------------------------------
  // saturating running total and output register
  // ---------------------------------------------------------------------------

  always_comb begin
    base      = tag_b_rst_r ? '0 : $signed(total_r);
    nt        = (TOTAL_W+1)'(base) + (TOTAL_W+1)'(charge);
    clip_hi   = !nt[TOTAL_W] && nt[TOTAL_W-1];
    clip_lo   = nt[TOTAL_W] && !nt[TOTAL_W-1];
    total_nxt = nt[TOTAL_W-1:0];
    if (clip_hi) begin
      total_nxt = TOTAL_MAX;
    end else if (clip_lo) begin
      total_nxt = TOTAL_MIN;
    end
    sat_nxt = (tag_b_rst_r ? 1'b0 : sat_r) | clip_hi | clip_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance && v_r[9]) begin
        total_r     <= total_nxt;
        sat_r       <= sat_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v_r[9]) begin
      out_site_r   <= tag_b_site_r;
      out_charge_r <= charge;
      out_total_r  <= total_nxt;
      out_sat_r    <= sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_site          = out_site_r;
  assign out_site_charge   = out_charge_r;
  assign out_running_total = $signed(out_total_r);
  assign out_saturated     = out_sat_r;

endmodule

`default_nettype wire

[sim/lattice_spin_chirality_tb.sv]
// lattice_spin_chirality_tb: self-checking bench for the scalar chirality engine
// loads sites, computes charges, checks each against a local predictor or typed row
// depends on lsc_pkg and lattice_spin_chirality
`default_nettype none

module lattice_spin_chirality_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam int RESET_CYCLES     = 6;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 30;
  localparam int RANDOM_PER_PHASE = 535;
  // a short run of large charges back to back at the end
  localparam int TAIL_COMPUTES    = 8;
  localparam int SITES            = LSC_MAX_SITES;

  // round(2^32 / (8 pi)) and the saturation bounds of the total
  localparam longint unsigned INV_8PI = 64'd170891319;
  localparam longint TOTAL_HI = 64'sd140737488355327;
  localparam longint TOTAL_LO = -TOTAL_HI - 64'sd1;

  // stored spins keep only the top bits when the block is built narrower
  localparam int KEEP_BITS = (LSC_SPIN_BITS < SPIN_W) ? LSC_SPIN_BITS : SPIN_W;
  localparam logic [SPIN_W-1:0] SPIN_MASK = {SPIN_W{1'b1}} << (SPIN_W - KEEP_BITS);

  typedef struct packed {
    logic                    func;
    logic [SITE_W-1:0]       site;
    vec_t                    spin;
    logic signed [NBR_W-1:0] nmx;
    logic signed [NBR_W-1:0] npx;
    logic signed [NBR_W-1:0] nmy;
    logic signed [NBR_W-1:0] npy;
    logic                    restart;
  } site_item_t;

  typedef struct packed {
    logic [SITE_W-1:0]          site;
    logic signed [CHARGE_W-1:0] charge;
    logic signed [TOTAL_W-1:0]  total;
    logic                       sat;
  } charge_report_t;

  // three sites whose two plaquettes give close to the largest positive charge
  localparam site_item_t TRIAD_A = {FUNC_LOAD, 10'd7, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                    11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b0};
  localparam site_item_t TRIAD_B = {FUNC_LOAD, 10'd8, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                                    11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b0};
  localparam site_item_t TRIAD_C = {FUNC_LOAD, 10'd6, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                    11'd7, 11'd7, 11'd8, 11'd8, 1'b0};

  // a site with no neighbours reports zero charge
  localparam charge_report_t NO_CHARGE = '0;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic [SITE_W-1:0] in_site;
  logic signed [SPIN_W-1:0] in_spin_x;
  logic signed [SPIN_W-1:0] in_spin_y;
  logic signed [SPIN_W-1:0] in_spin_z;
  logic signed [NBR_W-1:0] in_nbr_minus_x;
  logic signed [NBR_W-1:0] in_nbr_plus_x;
  logic signed [NBR_W-1:0] in_nbr_minus_y;
  logic signed [NBR_W-1:0] in_nbr_plus_y;
  logic in_restart;
  logic out_valid;
  logic out_stall;
  logic [SITE_W-1:0] out_site;
  logic signed [CHARGE_W-1:0] out_site_charge;
  logic signed [TOTAL_W-1:0] out_running_total;
  logic out_saturated;

  // hand-typed expectation riding along with the item on the input channel
  logic drv_typed;
  charge_report_t drv_typed_exp;

  // predictor state: a private copy of both stores, the total and the flag
  vec_t spin_mem [SITES];
  logic signed [NBR_W-1:0] link_mem [SITES][4];
  longint total_model;
  bit sat_model;
  charge_report_t expected_charges [$];

  // stimulus bookkeeping: only loaded sites are ever computed or linked to
  bit loaded [SITES];
  int loaded_sites [$];

  // directed table
  site_item_t table_items [$];
  bit table_typed [$];
  charge_report_t table_expect [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int quiet_cycles;

  lattice_spin_chirality u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_site           (in_site),
    .in_spin_x         (in_spin_x),
    .in_spin_y         (in_spin_y),
    .in_spin_z         (in_spin_z),
    .in_nbr_minus_x    (in_nbr_minus_x),
    .in_nbr_plus_x     (in_nbr_plus_x),
    .in_nbr_minus_y    (in_nbr_minus_y),
    .in_nbr_plus_y     (in_nbr_plus_y),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_site          (out_site),
    .out_site_charge   (out_site_charge),
    .out_running_total (out_running_total),
    .out_saturated     (out_saturated)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // scalar triple product a . (b x c), exact in units of 2^-45
  function automatic longint triple_product(vec_t a, vec_t b, vec_t c);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    ax = a.x; ay = a.y; az = a.z;
    bx = b.x; by = b.y; bz = b.z;
    cx = c.x; cy = c.y; cz = c.z;
    return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
  endfunction

  // absent neighbour (negative or past the lattice) is a zero vector
  function automatic vec_t spin_at(logic signed [NBR_W-1:0] idx);
    if (idx >= 0 && idx < SITES) begin
      return spin_mem[int'(idx)];
    end
    return '0;
  endfunction

  // multiply by round(2^32/(8 pi)) and divide by 2^47, half away from zero
  function automatic logic signed [CHARGE_W-1:0] scale_to_charge(longint sum);
    logic [63:0] mag, t, q;
    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
    t = (mag & 64'h1FF_FFFF) * INV_8PI + (64'd1 << 46);
    q = ((mag >> 25) * INV_8PI + (t >> 25)) >> 22;
    return (sum < 0) ? -q[CHARGE_W-1:0] : q[CHARGE_W-1:0];
  endfunction

  task automatic predict_site_charge(input logic [SITE_W-1:0] site, input logic restart,
                                     output charge_report_t r);
    vec_t s;
    longint sum, charge, next_total;
    s = spin_mem[site];
    // lower-left plaquette (-x, -y) plus upper-right plaquette (+x, +y)
    sum = triple_product(s, spin_at(link_mem[site][0]), spin_at(link_mem[site][2]))
        + triple_product(s, spin_at(link_mem[site][1]), spin_at(link_mem[site][3]));
    charge = scale_to_charge(sum);
    if (restart) begin
      total_model = 0;
      sat_model = 1'b0;
    end
    next_total = total_model + charge;
    if (next_total > TOTAL_HI) begin
      next_total = TOTAL_HI;
      sat_model = 1'b1;
    end else if (next_total < TOTAL_LO) begin
      next_total = TOTAL_LO;
      sat_model = 1'b1;
    end
    total_model = next_total;
    r.site = site;
    r.charge = charge[CHARGE_W-1:0];
    r.total = next_total[TOTAL_W-1:0];
    r.sat = sat_model;
  endtask

  // acceptance on both channels, prediction and checking, all on the rising edge
  always @(posedge clk) begin : charge_check
    charge_report_t want;
    charge_report_t got;
    bit busy;
    if (rst_n) begin
      busy = 1'b0;
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        if (in_func == FUNC_LOAD) begin
          spin_mem[in_site].x = in_spin_x & SPIN_MASK;
          spin_mem[in_site].y = in_spin_y & SPIN_MASK;
          spin_mem[in_site].z = in_spin_z & SPIN_MASK;
          link_mem[in_site][0] = in_nbr_minus_x;
          link_mem[in_site][1] = in_nbr_plus_x;
          link_mem[in_site][2] = in_nbr_minus_y;
          link_mem[in_site][3] = in_nbr_plus_y;
        end else begin
          // predictor always runs so its total follows the block
          predict_site_charge(in_site, in_restart, want);
          if (drv_typed) begin
            want = drv_typed_exp;
          end
          expected_charges.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        got = {out_site, out_site_charge, out_running_total, out_saturated};
        if (expected_charges.size() == 0) begin
          $display("%0t: unexpected result for site %0d", $time, got.site);
          fail_count++;
        end else begin
          want = expected_charges.pop_front();
          if (got.site !== want.site) begin
            $display("%0t: site expected %0d got %0d", $time, want.site, got.site);
            fail_count++;
          end
          if (got.charge !== want.charge) begin
            $display("%0t: site %0d charge expected %0d got %0d",
                     $time, want.site, want.charge, got.charge);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $display("%0t: site %0d total expected %0d got %0d",
                     $time, want.site, want.total, got.total);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: site %0d saturated expected %0d got %0d",
                     $time, want.site, want.sat, got.sat);
            fail_count++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  // nothing accepted for too long: the block is hung
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("lattice_spin_chirality: mismatch");
    $finish;
  end

  function automatic site_item_t load_item(int site, int x, int y, int z,
                                           int mx, int px, int my, int py);
    site_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.site = SITE_W'(site);
    it.spin.x = SPIN_W'(x);
    it.spin.y = SPIN_W'(y);
    it.spin.z = SPIN_W'(z);
    it.nmx = NBR_W'(mx);
    it.npx = NBR_W'(px);
    it.nmy = NBR_W'(my);
    it.npy = NBR_W'(py);
    return it;
  endfunction

  function automatic site_item_t compute_item(int site, bit restart);
    site_item_t it;
    it = '0;
    it.func = FUNC_COMPUTE;
    it.site = SITE_W'(site);
    it.restart = restart;
    return it;
  endfunction

  task automatic add_row(input site_item_t it, input bit typed, input charge_report_t exp_r);
    table_items.push_back(it);
    table_typed.push_back(typed);
    table_expect.push_back(exp_r);
  endtask

  task automatic mark_loaded(input logic [SITE_W-1:0] s);
    if (!loaded[s]) begin
      loaded[s] = 1'b1;
      loaded_sites.push_back(int'(s));
    end
  endtask

  function automatic logic signed [SPIN_W-1:0] random_spin();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // neighbour link: mostly a loaded site, sometimes absent (any negative index)
  function automatic logic signed [NBR_W-1:0] random_link();
    case ($urandom_range(7))
      0: return -11'sd1;
      1: return {1'b1, 10'($urandom)};
      default: return 11'(loaded_sites[$urandom_range(loaded_sites.size() - 1)]);
    endcase
  endfunction

  // called on a falling edge, returns on the falling edge after acceptance
  task automatic send_item(input site_item_t it, input bit typed, input charge_report_t exp_r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_site        <= it.site;
    in_spin_x      <= it.spin.x;
    in_spin_y      <= it.spin.y;
    in_spin_z      <= it.spin.z;
    in_nbr_minus_x <= it.nmx;
    in_nbr_plus_x  <= it.npx;
    in_nbr_minus_y <= it.nmy;
    in_nbr_plus_y  <= it.npy;
    in_restart     <= it.restart;
    drv_typed      <= typed;
    drv_typed_exp  <= exp_r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // random traffic: loads grow the set of usable sites, computes only touch that set
  task automatic send_random(input int count);
    site_item_t it;
    repeat (count) begin
      it.func = ($urandom_range(99) < 42) ? FUNC_LOAD : FUNC_COMPUTE;
      it.spin.x = random_spin();
      it.spin.y = random_spin();
      it.spin.z = random_spin();
      it.restart = ($urandom_range(15) == 0);
      if (it.func == FUNC_LOAD) begin
        if ($urandom_range(2) == 0) begin
          it.site = SITE_W'(loaded_sites[$urandom_range(loaded_sites.size() - 1)]);
        end else begin
          it.site = SITE_W'($urandom_range(SITES - 1));
        end
        // the site itself is written by this item, so it may be its own neighbour
        mark_loaded(it.site);
        it.nmx = random_link();
        it.npx = random_link();
        it.nmy = random_link();
        it.npy = random_link();
      end else begin
        it.site = SITE_W'(loaded_sites[$urandom_range(loaded_sites.size() - 1)]);
        // links on a compute item are ignored
        it.nmx = NBR_W'($urandom);
        it.npx = NBR_W'($urandom);
        it.nmy = NBR_W'($urandom);
        it.npy = NBR_W'($urandom);
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    site_item_t it;
    // every input known from time zero, reset held low
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_LOAD;
    in_site        = '0;
    in_spin_x      = '0;
    in_spin_y      = '0;
    in_spin_z      = '0;
    in_nbr_minus_x = '0;
    in_nbr_plus_x  = '0;
    in_nbr_minus_y = '0;
    in_nbr_plus_y  = '0;
    in_restart     = 1'b0;
    out_stall      = 1'b0;
    drv_typed      = 1'b0;
    drv_typed_exp  = '0;
    total_model    = 0;
    sat_model      = 1'b0;
    fail_count     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 49;

    // directed table
    // lone site with every link absent: zero charge, total still at its reset value
    add_row(load_item(0, 32767, 0, 0, -1, -1, -1, -1), 1'b0, '0);
    add_row(compute_item(0, 1'b0), 1'b1, NO_CHARGE);
    // unit vectors along -y and -z, every link negative, down to the most negative index
    add_row(load_item(1, 0, -32768, 0, -1024, -1024, -1024, -1024), 1'b0, '0);
    add_row(load_item(2, 0, 0, -32768, -1, -2, -512, -1024), 1'b0, '0);
    // -x, -y, -z on one plaquette: triple product -2^45, charge -(2^32/(8 pi))/4
    add_row(load_item(1023, -32768, 0, 0, 1, -1024, 2, -1), 1'b0, '0);
    add_row(compute_item(1023, 1'b1), 1'b1,
            {10'd1023, -32'sd42722830, -48'sd42722830, 1'b0});
    // extreme spins, a site linked to itself, all four links present
    add_row(load_item(3, -32768, -32768, -32768, 1023, 3, 0, 1), 1'b0, '0);
    add_row(load_item(512, 32767, 32767, 32767, 3, 1023, 1, 2), 1'b0, '0);
    add_row(compute_item(512, 1'b0), 1'b0, '0);
    add_row(compute_item(3, 1'b0), 1'b0, '0);
    add_row(load_item(4, 16'sh5555, -16'sh5556, 32767, 1023, 1023, 1023, 1023), 1'b0, '0);
    add_row(compute_item(4, 1'b1), 1'b0, '0);
    // overwrite a neighbour and recompute the site that uses it
    add_row(load_item(1, -1, 1, -32768, -1, -1, -1, -1), 1'b0, '0);
    add_row(compute_item(1023, 1'b0), 1'b0, '0);
    // restart on a zero-charge site clears the total
    add_row(compute_item(0, 1'b1), 1'b1, NO_CHARGE);
    // near-maximum positive charge, then its mirror with all components flipped
    add_row(TRIAD_A, 1'b0, '0);
    add_row(TRIAD_B, 1'b0, '0);
    add_row(TRIAD_C, 1'b0, '0);
    add_row(compute_item(6, 1'b0), 1'b0, '0);
    add_row(load_item(9, -32768, -32768, -32768, 7, 7, 8, 8), 1'b0, '0);
    add_row(compute_item(9, 1'b0), 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase 1: sender idles lightly, receiver often stalls
    foreach (table_items[i]) begin
      if (table_items[i].func == FUNC_LOAD) begin
        mark_loaded(table_items[i].site);
      end
      send_item(table_items[i], table_typed[i], table_expect[i]);
    end
    send_random(RANDOM_PER_PHASE);

    // phase 2: roles swapped
    send_idle_pct = 49;
    recv_idle_pct = 34;
    send_random(RANDOM_PER_PHASE);

    // phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    // reload the triad, accumulate large charges back to back, then restart
    send_item(TRIAD_A, 1'b0, '0);
    send_item(TRIAD_B, 1'b0, '0);
    send_item(TRIAD_C, 1'b0, '0);
    send_item(compute_item(6, 1'b1), 1'b0, '0);
    repeat (TAIL_COMPUTES) begin
      send_item(compute_item(6, 1'b0), 1'b0, '0);
    end
    send_item(compute_item(6, 1'b1), 1'b0, '0);
    in_valid <= 1'b0;

    // wait for the last results, then keep watching for strays for DRAIN_CYCLES
    while (expected_charges.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lattice_spin_chirality: match");
    end else begin
      $display("lattice_spin_chirality: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
